### src/kmst_pkg.sv
`default_nettype none
package kmst_pkg;
   localparam int unsigned MAX_NODES_DEF   = 128;
   localparam int unsigned MAX_EDGES_DEF   = 1024;
   localparam int unsigned WEIGHT_BITS_DEF = 16;
   localparam int unsigned NODE_BITS       = 7;
   localparam int unsigned COUNT_BITS      = 8;
   localparam int unsigned IN_WEIGHT_BITS  = 16;
   localparam int unsigned SUM_BITS        = 24;
   localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] NODE_COUNT_RESET = 8'd128;
endpackage
`default_nettype wire

### src/kruskal_mst_weight_unit.sv
`default_nettype none
// Kruskal minimum spanning tree weight unit.
// req_ channel: one beat per edge (req_has_edge, req_node_a, req_node_b,
// req_weight). A beat with req_last_edge high closes the graph; its edge,
// if any, is stored first. Edge beats are taken one per cycle while idle.
// After the closing beat req_stall stays high during the computation:
// a parent table init over the clamped node count, then repeated scans
// of the edge store: a first scan for the lowest weight, then one scan
// per distinct weight, in which each edge of that weight takes two finds
// up the parent table. The run ends early when the tree is complete. The
// finds share the single parent table port; the edge store has one read port.
// rsp_ channel: one beat per closing beat, held in an output register
// until rsp_stall is low. A finished run waits there if the previous beat
// has not been taken yet.
// csr_ channel: writes node_count; csr_ready is always high. Write only
// while idle.
// reset (synchronous) empties the edge store, clears the flags and sets
// node_count to 128. Edges beyond the store size are dropped and flagged.
module kruskal_mst_weight_unit #(
   parameter int unsigned MAX_NODES   = kmst_pkg::MAX_NODES_DEF,
   parameter int unsigned MAX_EDGES   = kmst_pkg::MAX_EDGES_DEF,
   parameter int unsigned WEIGHT_BITS = kmst_pkg::WEIGHT_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [kmst_pkg::COUNT_BITS-1:0]      csr_node_count,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_has_edge,
   input  wire logic [kmst_pkg::NODE_BITS-1:0]       req_node_a,
   input  wire logic [kmst_pkg::NODE_BITS-1:0]       req_node_b,
   input  wire logic [kmst_pkg::IN_WEIGHT_BITS-1:0]  req_weight,
   input  wire logic                                 req_last_edge,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [kmst_pkg::SUM_BITS-1:0]             rsp_total_weight,
   output logic                                      rsp_connected,
   output logic                                      rsp_overflow
);
   localparam int unsigned NB = $clog2(MAX_NODES);
   localparam int unsigned NW = NB + 1;
   localparam int unsigned EB = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int unsigned EW = EB + 1;
   localparam int unsigned NDB = kmst_pkg::NODE_BITS;

   typedef struct packed {
      logic [WEIGHT_BITS-1:0] w;
      logic [NDB-1:0]         a;
      logic [NDB-1:0]         b;
   } edge_type;

   typedef enum logic [2:0] {
      S_IDLE, S_INIT, S_RD, S_EW, S_FWAIT, S_FCHK, S_DONE
   } state_type;

   state_type               state_ff;
   edge_type                emem [MAX_EDGES];
   edge_type                edata_ff;
   logic [NB-1:0]           pmem [MAX_NODES];
   logic [NB-1:0]           pdata_ff;
   logic [NB-1:0]           paddr_ff;
   logic                    p_we;
   logic [NB-1:0]           p_wa, p_wd;
   logic                    e_we;
   edge_type                e_wd;

   logic [kmst_pkg::COUNT_BITS-1:0] ncfg_ff;
   logic [NW-1:0]           n_ff, n_in;
   logic [EW-1:0]           etot_ff;
   logic [EW-1:0]           e_ff;
   logic                    drop_ff;
   logic [NB-1:0]           i_ff;
   logic [NB-1:0]           taken_ff;
   logic [kmst_pkg::SUM_BITS-1:0] sum_ff;
   logic [WEIGHT_BITS-1:0]  cur_w_ff, next_w_ff;
   logic                    have_cur_ff, have_next_ff;
   logic [NB-1:0]           x_ff, ra_ff, b_ff;
   logic [WEIGHT_BITS-1:0]  ew_ff;
   logic                    which_ff;
   logic                    rsp_valid_ff;
   logic [kmst_pkg::SUM_BITS-1:0] rsp_total_ff;
   logic                    rsp_conn_ff, rsp_ovf_ff;

   logic                    req_take;
   logic                    ep_ok, proc, cand;
   logic [32:0]             sum_wide;
   logic [kmst_pkg::SUM_BITS-1:0] sum_sat;
   logic                    conn;

   assign csr_ready        = 1'b1;
   assign req_stall        = (state_ff != S_IDLE);
   assign req_take         = req_valid && !req_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_total_weight = rsp_total_ff;
   assign rsp_connected    = rsp_conn_ff;
   assign rsp_overflow     = rsp_ovf_ff;

   always_comb begin
      if (ncfg_ff == '0) begin
         n_in = NW'(1);
      end else if (int'(ncfg_ff) > int'(MAX_NODES)) begin
         n_in = NW'(MAX_NODES);
      end else begin
         n_in = NW'(ncfg_ff);
      end
   end

   always_comb begin
      ep_ok = (int'(edata_ff.a) < int'(n_ff)) && (int'(edata_ff.b) < int'(n_ff))
              && (edata_ff.a != edata_ff.b);
      proc  = have_cur_ff && (edata_ff.w == cur_w_ff) && ep_ok;
      cand  = !have_cur_ff || (edata_ff.w > cur_w_ff);
      sum_wide = 33'(sum_ff) + 33'(ew_ff);
      sum_sat  = (sum_wide > 33'(kmst_pkg::SUM_MAX)) ? kmst_pkg::SUM_MAX
                 : sum_wide[kmst_pkg::SUM_BITS-1:0];
      conn = (NW'(taken_ff) == n_ff - NW'(1));
   end

   always_comb begin
      e_we = req_take && req_has_edge && (int'(etot_ff) < int'(MAX_EDGES));
      e_wd.w = WEIGHT_BITS'(req_weight);
      e_wd.a = req_node_a;
      e_wd.b = req_node_b;
      p_we = 1'b0;
      p_wa = i_ff;
      p_wd = i_ff;
      if (state_ff == S_INIT) begin
         p_we = 1'b1;
      end else if (state_ff == S_FCHK && pdata_ff == x_ff && which_ff
                   && ra_ff != x_ff) begin
         p_we = 1'b1;
         p_wa = (ra_ff < x_ff) ? x_ff : ra_ff;
         p_wd = (ra_ff < x_ff) ? ra_ff : x_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (e_we) begin
         emem[etot_ff[EB-1:0]] <= e_wd;
      end
      edata_ff <= emem[e_ff[EB-1:0]];
   end

   always_ff @(posedge clock) begin
      if (p_we) begin
         pmem[p_wa] <= p_wd;
      end
      pdata_ff <= pmem[paddr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ncfg_ff      <= kmst_pkg::NODE_COUNT_RESET;
         etot_ff      <= '0;
         drop_ff      <= 1'b0;
         taken_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         have_cur_ff  <= 1'b0;
         have_next_ff <= 1'b0;
         which_ff     <= 1'b0;
         i_ff         <= '0;
         e_ff         <= '0;
      end else begin
         if (csr_valid) begin
            ncfg_ff <= csr_node_count;
         end
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  if (e_we) begin
                     etot_ff <= etot_ff + EW'(1);
                  end else if (req_has_edge) begin
                     drop_ff <= 1'b1;
                  end
                  if (req_last_edge) begin
                     n_ff         <= n_in;
                     i_ff         <= '0;
                     taken_ff     <= '0;
                     sum_ff       <= '0;
                     have_cur_ff  <= 1'b0;
                     have_next_ff <= 1'b0;
                     state_ff     <= S_INIT;
                  end
               end
            end
            S_INIT: begin
               i_ff <= i_ff + NB'(1);
               if (NW'(i_ff) == n_ff - NW'(1)) begin
                  e_ff     <= '0;
                  state_ff <= (n_ff == NW'(1)) ? S_DONE : S_RD;
               end
            end
            S_RD: begin
               if (e_ff == etot_ff) begin
                  if (have_next_ff) begin
                     cur_w_ff     <= next_w_ff;
                     have_cur_ff  <= 1'b1;
                     have_next_ff <= 1'b0;
                     e_ff         <= '0;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end else begin
                  state_ff <= S_EW;
               end
            end
            S_EW: begin
               if (cand && (!have_next_ff || edata_ff.w < next_w_ff)) begin
                  next_w_ff    <= edata_ff.w;
                  have_next_ff <= 1'b1;
               end
               if (proc) begin
                  x_ff     <= NB'(edata_ff.a);
                  paddr_ff <= NB'(edata_ff.a);
                  b_ff     <= NB'(edata_ff.b);
                  ew_ff    <= edata_ff.w;
                  which_ff <= 1'b0;
                  state_ff <= S_FWAIT;
               end else begin
                  e_ff     <= e_ff + EW'(1);
                  state_ff <= S_RD;
               end
            end
            S_FWAIT: begin
               state_ff <= S_FCHK;
            end
            S_FCHK: begin
               if (pdata_ff != x_ff) begin
                  x_ff     <= pdata_ff;
                  paddr_ff <= pdata_ff;
                  state_ff <= S_FWAIT;
               end else if (!which_ff) begin
                  ra_ff    <= x_ff;
                  x_ff     <= b_ff;
                  paddr_ff <= b_ff;
                  which_ff <= 1'b1;
                  state_ff <= S_FWAIT;
               end else begin
                  e_ff <= e_ff + EW'(1);
                  if (ra_ff != x_ff) begin
                     taken_ff <= taken_ff + NB'(1);
                     sum_ff   <= sum_sat;
                     state_ff <= (NW'(taken_ff) + NW'(1) == n_ff - NW'(1)) ? S_DONE : S_RD;
                  end else begin
                     state_ff <= S_RD;
                  end
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_total_ff <= conn ? sum_ff : '0;
                  rsp_conn_ff  <= conn;
                  rsp_ovf_ff   <= drop_ff;
                  etot_ff      <= '0;
                  drop_ff      <= 1'b0;
                  taken_ff     <= '0;
                  sum_ff       <= '0;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end
endmodule
`default_nettype wire
